[hdl/ab3_pkg.sv]
// Types, codes and constants shared by the Adams-Bashforth integrator modules.
`timescale 1ns / 1ps
`default_nettype none

package ab3_pkg;

   // Field widths.
   localparam int IDX_W  = 4;
   localparam int VAL_W  = 32;
   localparam int TIME_W = 48;
   localparam int STEP_W = 24;

   // Step size after reset, Q0.24.
   localparam logic [STEP_W-1:0] STEP_RESET = 24'd16777;

   // Starter phases; the last one is the steady phase.
   localparam logic [3:0] PHASE_1      = 4'd1;
   localparam logic [3:0] PHASE_2      = 4'd2;
   localparam logic [3:0] PHASE_3      = 4'd3;
   localparam logic [3:0] PHASE_4      = 4'd4;
   localparam logic [3:0] PHASE_5      = 4'd5;
   localparam logic [3:0] PHASE_6      = 4'd6;
   localparam logic [3:0] PHASE_STEADY = 4'd8;

   // Datapath widths: weighted sum, low split of the sum, full product.
   localparam int SUM_W    = 38;
   localparam int SUM_LO_W = 18;
   localparam int PLO_W    = STEP_W + SUM_LO_W;
   localparam int PHI_W    = STEP_W + 1 + SUM_W - SUM_LO_W;
   localparam int PROD_W   = 62;

   // Right shifts that take out 2^24 and the power-of-two part of the divisor.
   localparam logic [4:0] SHIFT_BY_4  = 5'd26;
   localparam logic [4:0] SHIFT_BY_8  = 5'd27;
   localparam logic [4:0] SHIFT_BY_16 = 5'd28;

   // Weights of the Adams-Bashforth sum.
   localparam logic signed [SUM_W-1:0] COEF_NEW  = SUM_W'(23);
   localparam logic signed [SUM_W-1:0] COEF_MID  = SUM_W'(16);
   localparam logic signed [SUM_W-1:0] COEF_OLD  = SUM_W'(5);
   localparam logic signed [SUM_W-1:0] COEF_HALF = SUM_W'(3);

   // Divide-by-three unit: dividend width, bits per cycle, cycles.
   localparam int DIV_W      = 36;
   localparam int DIV_STEP   = 9;
   localparam int DIV_CYCLES = DIV_W / DIV_STEP;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

   // The scaled product is clipped to +/-2^34 (far past saturation) and then
   // biased by 3*2^33 so that the divide-by-three sees a positive number.
   localparam logic signed [PROD_W-1:0] Q_MAX = (PROD_W'(1) << 34) - PROD_W'(1);
   localparam logic signed [PROD_W-1:0] Q_MIN = -(PROD_W'(1) << 34);
   localparam logic [PROD_W-1:0] DIV_OFFSET   = PROD_W'(3) << 33;
   localparam logic [DIV_W-1:0] BIAS_DIRECT   = DIV_W'(3) << 33;
   localparam logic [DIV_W-1:0] BIAS_DIV3     = DIV_W'(1) << 33;

   typedef struct packed {
      logic [IDX_W-1:0]         elem_index;
      logic signed [VAL_W-1:0]  state_value;
      logic signed [VAL_W-1:0]  derivative;
      logic [TIME_W-1:0]        time_now;
      logic                     last_element;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         out_index;
      logic signed [VAL_W-1:0]  next_value;
      logic [TIME_W-1:0]        next_time;
      logic                     saturated;
      logic                     last_out;
   } rsp_type;

   // One history memory word: the four derivative history values of an element.
   typedef struct packed {
      logic signed [VAL_W-1:0] full_new;
      logic signed [VAL_W-1:0] full_old;
      logic signed [VAL_W-1:0] sub_new;
      logic signed [VAL_W-1:0] sub_old;
   } hist_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_ACC,
      ST_SCALE,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

`default_nettype wire

[hdl/ab3_div3.sv]
// Multicycle floor divide by three of an unsigned word, several bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ab3_div3
   import ab3_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   output logic                  busy,
   output logic [DIV_W-1:0]      quotient
);

   logic [DIV_W-1:0]     num_ff, num_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [1:0]           rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;

   // Long division by three, most significant bit first, one chunk a cycle.
   always_comb begin
      logic [2:0] part;
      logic [1:0] rem;
      logic [DIV_W-1:0] quo;
      rem = rem_ff;
      quo = quo_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         part = {rem, num_ff[DIV_W-1-i]};
         quo  = {quo[DIV_W-2:0], (part >= 3'd3)};
         if (part >= 3'd3) begin
            part = part - 3'd3;
         end
         rem = part[1:0];
      end
      if (start) begin
         num_in   = dividend;
         quo_in   = '0;
         rem_in   = '0;
         count_in = DIV_CNT_W'(DIV_CYCLES);
      end else if (count_ff != '0) begin
         num_in   = num_ff << DIV_STEP;
         quo_in   = quo;
         rem_in   = rem;
         count_in = count_ff - DIV_CNT_W'(1);
      end else begin
         num_in   = num_ff;
         quo_in   = quo_ff;
         rem_in   = rem_ff;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = (count_ff != '0);
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[hdl/adams_bashforth3_integrator.sv]
// Top level of the third-order Adams-Bashforth integrator with its starter phases.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_payload (req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_payload (rsp_type)
//   csr      in         csr_write_enable       csr_write_data (step size, Q0.24)
//
// One request is worked at a time. An accepted request passes through the sum,
// multiply, accumulate, scale and final steps before the next one is accepted; in
// phase 3 and all later phases a divide-by-three step lies between scale and final,
// and the block waits there until the divider has its quotient.
// The history memory is read at acceptance and written back in the next cycle.
// A finished response waits in the output register; the block stalls in its last
// step only when that register is still full. Reset is synchronous and needs no
// clearing pass; the history memory holds no reset value.
`timescale 1ns / 1ps
`default_nettype none

module adams_bashforth3_integrator
   import ab3_pkg::*;
#(
   parameter int MAX_STATES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_payload,
   input  wire logic              csr_write_enable,
   input  wire logic [STEP_W-1:0] csr_write_data
);

   localparam int ADDR_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;

   state_type state_ff, state_in;

   logic [STEP_W-1:0]       step_size_ff, step_size_in;
   logic [3:0]              phase_ff, phase_in;
   req_type                 req_ff;
   logic                    ok_ff;
   logic [ADDR_W-1:0]       addr_ff;
   hist_type                mem_rdata_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [4:0]              shift_ff, shift_in;
   logic                    div3_ff, div3_in;
   logic [STEP_W-1:0]       dt_ff, dt_in;
   logic [PLO_W-1:0]        plo_ff, plo_in;
   logic signed [PHI_W-1:0] phi_ff, phi_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [DIV_W-1:0]        scaled_ff, scaled_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   hist_type hist_mem [0:MAX_STATES-1];
   hist_type hist_rd;
   hist_type hist_wr;

   logic              req_accept;
   logic              in_range;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;
   logic              div_start;
   logic              div_busy;
   logic [DIV_W-1:0]  div_quotient;
   logic              rsp_free;
   logic              rsp_load;

   // Request decode: elements past the memory read and write no history.
   assign req_accept = req_valid && req_ready;
   assign in_range   = (32'(req_payload.elem_index) < MAX_STATES);
   assign rd_addr    = in_range ? ADDR_W'(req_payload.elem_index) : '0;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_SUM;
         ST_SUM:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_SCALE;
         ST_SCALE: state_in = div3_ff ? ST_DIV : ST_FIN;
         ST_DIV:   if (!div_busy) state_in = ST_FIN;
         ST_FIN:   if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_SUM:   mem_we    = ok_ff;
         ST_SCALE: div_start = div3_ff;
         ST_FIN:   rsp_load  = rsp_free;
         default:  req_ready = 1'b0;
      endcase
   end

   // Weighted derivative sum, divisor and history shuffle for the current phase.
   always_comb begin
      logic signed [SUM_W-1:0] yp;
      logic signed [SUM_W-1:0] sub_sum;
      logic signed [SUM_W-1:0] full_sum;
      hist_rd  = ok_ff ? mem_rdata_ff : '0;
      yp       = SUM_W'(req_ff.derivative);
      sub_sum  = yp * COEF_NEW - SUM_W'(hist_rd.sub_new) * COEF_MID
               + SUM_W'(hist_rd.sub_old) * COEF_OLD;
      full_sum = yp * COEF_NEW - SUM_W'(hist_rd.full_new) * COEF_MID
               + SUM_W'(hist_rd.full_old) * COEF_OLD;
      hist_wr  = hist_rd;
      case (phase_ff)
         PHASE_1: begin
            sum_in           = yp;
            shift_in         = SHIFT_BY_4;
            div3_in          = 1'b0;
            dt_in            = step_size_ff >> 2;
            hist_wr.full_old = req_ff.derivative;
            hist_wr.sub_old  = req_ff.derivative;
         end
         PHASE_2: begin
            sum_in          = yp * COEF_HALF - SUM_W'(hist_rd.sub_old);
            shift_in        = SHIFT_BY_8;
            div3_in         = 1'b0;
            dt_in           = step_size_ff >> 2;
            hist_wr.sub_new = req_ff.derivative;
         end
         PHASE_3: begin
            sum_in          = sub_sum;
            shift_in        = SHIFT_BY_16;
            div3_in         = 1'b1;
            dt_in           = step_size_ff >> 2;
            hist_wr.sub_old = hist_rd.sub_new;
            hist_wr.sub_new = req_ff.derivative;
         end
         PHASE_4: begin
            sum_in          = sub_sum;
            shift_in        = SHIFT_BY_16;
            div3_in         = 1'b1;
            dt_in           = step_size_ff >> 2;
            hist_wr.sub_old = hist_rd.full_old;
         end
         PHASE_5: begin
            sum_in           = sub_sum;
            shift_in         = SHIFT_BY_8;
            div3_in          = 1'b1;
            dt_in            = step_size_ff >> 1;
            hist_wr.full_new = req_ff.derivative;
            hist_wr.sub_old  = hist_rd.sub_new;
            hist_wr.sub_new  = req_ff.derivative;
         end
         PHASE_6: begin
            sum_in          = sub_sum;
            shift_in        = SHIFT_BY_8;
            div3_in         = 1'b1;
            dt_in           = step_size_ff >> 1;
            hist_wr.sub_old = hist_rd.sub_new;
            hist_wr.sub_new = req_ff.derivative;
         end
         default: begin
            sum_in           = full_sum;
            shift_in         = SHIFT_BY_4;
            div3_in          = 1'b1;
            dt_in            = step_size_ff;
            hist_wr.full_old = hist_rd.full_new;
            hist_wr.full_new = req_ff.derivative;
         end
      endcase
   end

   // The phase moves on after the last element of a vector and stops at steady.
   always_comb begin
      phase_in = phase_ff;
      if (state_ff == ST_SUM && req_ff.last_element && phase_ff != PHASE_STEADY) begin
         phase_in = phase_ff + 4'd1;
      end
   end

   assign step_size_in = csr_write_enable ? csr_write_data : step_size_ff;

   // Step size times sum, split in two partial products, then joined.
   assign plo_in  = step_size_ff * sum_ff[SUM_LO_W-1:0];
   assign phi_in  = $signed({1'b0, step_size_ff}) * $signed(sum_ff[SUM_W-1:SUM_LO_W]);
   assign prod_in = (PROD_W'(phi_ff) <<< SUM_LO_W) + PROD_W'(plo_ff);

   // Floor shift, clip far past the saturation limits, and bias positive.
   always_comb begin
      logic signed [PROD_W-1:0] q;
      logic signed [PROD_W-1:0] qc;
      q = prod_ff >>> shift_ff;
      if (q > Q_MAX) begin
         qc = Q_MAX;
      end else if (q < Q_MIN) begin
         qc = Q_MIN;
      end else begin
         qc = q;
      end
      scaled_in = DIV_W'(qc + DIV_OFFSET);
   end

   ab3_div3 u_div3 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scaled_in),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   // Remove the bias, add to the state value and saturate.
   always_comb begin
      logic [DIV_W-1:0]        base;
      logic [DIV_W-1:0]        bias;
      logic signed [DIV_W:0]   inc;
      logic signed [SUM_W-1:0] total;
      base  = div3_ff ? div_quotient : scaled_ff;
      bias  = div3_ff ? BIAS_DIV3 : BIAS_DIRECT;
      inc   = $signed({1'b0, base}) - $signed({1'b0, bias});
      total = SUM_W'(req_ff.state_value) + SUM_W'(inc);
      rsp_in.out_index = req_ff.elem_index;
      rsp_in.next_time = req_ff.time_now + TIME_W'(dt_ff);
      rsp_in.last_out  = req_ff.last_element;
      if (total[SUM_W-1:VAL_W-1] != {(SUM_W-VAL_W+1){total[SUM_W-1]}}) begin
         rsp_in.saturated  = 1'b1;
         rsp_in.next_value = total[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                            : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         rsp_in.saturated  = 1'b0;
         rsp_in.next_value = total[VAL_W-1:0];
      end
   end

   // Output register: filled from the last step, emptied by the consumer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PHASE_1;
         step_size_ff <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_size_ff <= step_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // History memory: read at acceptance, written back in the cycle after. Only one
   // request is in flight, so a read never meets a pending write to its entry.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mem_rdata_ff <= hist_mem[rd_addr];
      end
      if (mem_we) begin
         hist_mem[addr_ff] <= hist_wr;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff  <= req_payload;
         ok_ff   <= in_range;
         addr_ff <= rd_addr;
      end
      if (state_ff == ST_SUM) begin
         sum_ff   <= sum_in;
         shift_ff <= shift_in;
         div3_ff  <= div3_in;
         dt_ff    <= dt_in;
      end
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      prod_ff   <= prod_in;
      if (state_ff == ST_SCALE) begin
         scaled_ff <= scaled_in;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   // A response appears only out of the final step.
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside the final step");

   // The phase counter stays within the starter and steady phases.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff >= PHASE_1 && phase_ff <= PHASE_STEADY)
      else $error("phase counter out of range");

   // The phase moves only after the history step of a last element.
   a_phase_advance: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && phase_ff != $past(phase_ff)
      |-> $past(state_ff == ST_SUM && req_ff.last_element))
      else $error("phase changed without a last element");

   // The divider runs only while the sequencer waits on it.
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_DIV |-> !div_busy)
      else $error("divider busy outside its step");
`endif

endmodule

`default_nettype wire

[tb/sv/adams_bashforth3_integrator_tb.sv]
// Self-checking testbench for the Adams-Bashforth integrator: starter, steady phase, step sizes.
`timescale 1ns / 1ps

module adams_bashforth3_integrator_tb;
   import ab3_pkg::*;

   localparam int     MAX_STATES     = 16;
   localparam int     RESET_CYCLES   = 6;
   localparam int     SEGMENT_ITEMS  = 66;
   localparam int     DRAIN_SETTLE   = 12;
   localparam int     END_CYCLES     = 24;
   localparam int     HOLD_AT        = 150;
   localparam int     HOLD_CYCLES    = 300;
   localparam int     WATCHDOG_LIMIT = 3000;
   localparam longint VALUE_MAX      = 64'sh7FFF_FFFF;
   localparam longint VALUE_MIN      = -64'sh8000_0000;

   // Kinds of entries in the stimulus queue.
   typedef enum logic [1:0] {
      OP_REQUEST,
      OP_DRAIN,
      OP_CSR
   } stim_kind_type;

   typedef struct {
      stim_kind_type     kind;
      req_type           payload;
      logic [STEP_W-1:0] step;
   } stim_op_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   req_type           req_payload      = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_write_enable = 1'b0;
   logic [STEP_W-1:0] csr_write_data   = '0;

   // Stimulus and checking state.
   stim_op_type pending_ops [$];
   rsp_type     awaited_rsp [$];
   logic        req_taken    = 1'b0;
   int          items_total  = 0;
   int          req_accepted = 0;
   int          rsp_seen     = 0;
   int          fail_count   = 0;
   int          idle_cycles  = 0;
   int          directed_n   = 0;

   // Integrator state as the testbench sees it.
   logic [STEP_W-1:0]       step_model  = STEP_RESET;
   logic [3:0]              phase_model = PHASE_1;
   logic signed [VAL_W-1:0] hist_fn [MAX_STATES];
   logic signed [VAL_W-1:0] hist_fo [MAX_STATES];
   logic signed [VAL_W-1:0] hist_sn [MAX_STATES];
   logic signed [VAL_W-1:0] hist_so [MAX_STATES];

   adams_bashforth3_integrator #(
      .MAX_STATES(MAX_STATES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always #6 clock = ~clock;

   // Unwritten history words read as zero; the stimulus never uses one anyway.
   initial begin
      for (int i = 0; i < MAX_STATES; i++) begin
         hist_fn[i] = '0;
         hist_fo[i] = '0;
         hist_sn[i] = '0;
         hist_so[i] = '0;
      end
   end

   // Advances one element by one sub-step and updates history and phase.
   function automatic rsp_type integrate_element(req_type r);
      rsp_type           o;
      longint            fn, fo, sn, so, yp, s, den, prod, inc, v;
      logic [TIME_W-1:0] dt;
      fn = hist_fn[r.elem_index];
      fo = hist_fo[r.elem_index];
      sn = hist_sn[r.elem_index];
      so = hist_so[r.elem_index];
      yp = r.derivative;
      case (phase_model)
         PHASE_1: begin
            s = yp; den = 4; dt = TIME_W'(step_model >> 2);
            fo = yp; so = yp;
         end
         PHASE_2: begin
            s = 3 * yp - so; den = 8; dt = TIME_W'(step_model >> 2);
            sn = yp;
         end
         PHASE_3: begin
            s = 23 * yp - 16 * sn + 5 * so; den = 48; dt = TIME_W'(step_model >> 2);
            so = sn; sn = yp;
         end
         PHASE_4: begin
            s = 23 * yp - 16 * sn + 5 * so; den = 48; dt = TIME_W'(step_model >> 2);
            so = fo;
         end
         PHASE_5: begin
            s = 23 * yp - 16 * sn + 5 * so; den = 24; dt = TIME_W'(step_model >> 1);
            fn = yp; so = sn; sn = yp;
         end
         PHASE_6: begin
            s = 23 * yp - 16 * sn + 5 * so; den = 24; dt = TIME_W'(step_model >> 1);
            so = sn; sn = yp;
         end
         default: begin
            s = 23 * yp - 16 * fn + 5 * fo; den = 12; dt = TIME_W'(step_model);
            fo = fn; fn = yp;
         end
      endcase

      // The increment is rounded toward minus infinity, then the sum saturates.
      prod = longint'(step_model) * s;
      den  = den * 16777216;
      inc  = prod / den;
      if (prod % den != 0 && prod < 0) inc = inc - 1;
      v = longint'(r.state_value) + inc;
      o.saturated = 1'b0;
      if (v > VALUE_MAX) begin
         v = VALUE_MAX;
         o.saturated = 1'b1;
      end
      if (v < VALUE_MIN) begin
         v = VALUE_MIN;
         o.saturated = 1'b1;
      end

      hist_fn[r.elem_index] = fn[VAL_W-1:0];
      hist_fo[r.elem_index] = fo[VAL_W-1:0];
      hist_sn[r.elem_index] = sn[VAL_W-1:0];
      hist_so[r.elem_index] = so[VAL_W-1:0];
      if (r.last_element && phase_model < PHASE_STEADY) phase_model = phase_model + 4'd1;

      o.out_index  = r.elem_index;
      o.next_value = v[VAL_W-1:0];
      o.next_time  = r.time_now + dt;
      o.last_out   = r.last_element;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      fail_count++;
   endtask

   // Mostly short gaps, a few long ones, and now and then a burst with none.
   function automatic int pick_gap(inout int burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if (r < 4) begin
         burst = $urandom_range(16, 48);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return '1;
         4:       return 32'(int'($urandom_range(0, 2000)) - 1000);
         default: return $urandom();
      endcase
   endfunction

   // The first requests walk all corner pairs of value and derivative; later ones are random.
   task automatic push_request(input logic [IDX_W-1:0] idx, input logic last);
      stim_op_type            op;
      logic [VAL_W-1:0]       corner [4];
      corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
      op.kind                 = OP_REQUEST;
      op.step                 = '0;
      op.payload.elem_index   = idx;
      op.payload.last_element = last;
      if (directed_n < 24) begin
         op.payload.state_value = corner[directed_n % 4];
         op.payload.derivative  = (directed_n < 16) ? corner[(directed_n / 4) % 4] : pick_value();
         case (directed_n % 3)
            0:       op.payload.time_now = '1;
            1:       op.payload.time_now = '0;
            default: op.payload.time_now = TIME_W'({$urandom(), $urandom()});
         endcase
      end else begin
         op.payload.state_value = pick_value();
         op.payload.derivative  = pick_value();
         op.payload.time_now    = TIME_W'({$urandom(), $urandom()});
      end
      directed_n++;
      items_total++;
      pending_ops.push_back(op);
   endtask

   // A vector either sweeps every index in shuffled order plus extras, or is all random indexes.
   task automatic push_vector(input bit sweep, input int extra);
      logic [IDX_W-1:0] order [MAX_STATES];
      logic [IDX_W-1:0] tmp;
      int               j, total;
      for (int i = 0; i < MAX_STATES; i++) order[i] = IDX_W'(i);
      for (int i = MAX_STATES - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      total = sweep ? MAX_STATES + extra : extra;
      for (int i = 0; i < total; i++) begin
         push_request((sweep && i < MAX_STATES) ? order[i]
                                                : IDX_W'($urandom_range(0, MAX_STATES - 1)),
                      i == total - 1);
      end
   endtask

   // A step size is only changed once every response is back.
   task automatic push_step_size(input logic [STEP_W-1:0] step);
      stim_op_type op;
      op.payload = '0;
      op.step    = step;
      op.kind    = OP_DRAIN;
      pending_ops.push_back(op);
      op.kind    = OP_CSR;
      pending_ops.push_back(op);
   endtask

   // Request driver: holds a request until taken, then idles or pops the next entry.
   always @(negedge clock) begin : request_driver
      logic              valid_n;
      req_type           payload_n;
      logic              we_n;
      logic [STEP_W-1:0] data_n;
      int                send_gap;
      int                send_burst;
      int                settle_count;
      valid_n   = req_valid;
      payload_n = req_payload;
      we_n      = 1'b0;
      data_n    = csr_write_data;
      if (reset) begin
         valid_n      = 1'b0;
         send_gap     = 0;
         send_burst   = 0;
         settle_count = 0;
      end else if (!(req_valid && !req_taken)) begin
         valid_n = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_ops.size() != 0) begin
            case (pending_ops[0].kind)
               OP_REQUEST: begin
                  payload_n = pending_ops[0].payload;
                  valid_n   = 1'b1;
                  void'(pending_ops.pop_front());
                  send_gap  = pick_gap(send_burst);
               end
               OP_DRAIN: begin
                  if (awaited_rsp.size() != 0) begin
                     settle_count = 0;
                  end else if (settle_count < DRAIN_SETTLE) begin
                     settle_count++;
                  end else begin
                     settle_count = 0;
                     void'(pending_ops.pop_front());
                  end
               end
               default: begin
                  we_n   = 1'b1;
                  data_n = pending_ops[0].step;
                  void'(pending_ops.pop_front());
               end
            endcase
         end
      end
      req_valid        <= valid_n;
      req_payload      <= payload_n;
      csr_write_enable <= we_n;
      csr_write_data   <= data_n;
   end

   // Response sink: random gaps plus one long hold-off that lets the block back up.
   always @(negedge clock) begin : response_sink
      logic ready_n;
      int   sink_gap;
      int   sink_burst;
      int   hold_left;
      bit   hold_done;
      ready_n = 1'b0;
      if (reset) begin
         sink_gap   = 0;
         sink_burst = 0;
         hold_left  = 0;
         hold_done  = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
      end else if (!hold_done && rsp_seen >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end else if (sink_gap > 0) begin
         sink_gap--;
      end else begin
         ready_n  = 1'b1;
         sink_gap = pick_gap(sink_burst);
      end
      rsp_ready <= ready_n;
   end

   // Monitor: predicts on each accepted request and checks each accepted response.
   always @(posedge clock) begin : channel_monitor
      rsp_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (csr_write_enable) step_model = csr_write_data;
         if (req_valid && req_ready) begin
            awaited_rsp.push_back(integrate_element(req_payload));
            req_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (awaited_rsp.size() == 0) begin
               report_mismatch("response with none awaited", 64'(rsp_payload), '0);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_payload.out_index !== want.out_index)
                  report_mismatch("out_index", 64'(rsp_payload.out_index),
                                  64'(want.out_index));
               if (rsp_payload.next_value !== want.next_value)
                  report_mismatch("next_value", 64'(rsp_payload.next_value),
                                  64'(want.next_value));
               if (rsp_payload.next_time !== want.next_time)
                  report_mismatch("next_time", 64'(rsp_payload.next_time),
                                  64'(want.next_time));
               if (rsp_payload.saturated !== want.saturated)
                  report_mismatch("saturated", 64'(rsp_payload.saturated),
                                  64'(want.saturated));
               if (rsp_payload.last_out !== want.last_out)
                  report_mismatch("last_out", 64'(rsp_payload.last_out),
                                  64'(want.last_out));
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("adams_bashforth3_integrator verification failed");
         $finish;
      end
   end

   // Builds the stimulus, releases reset and waits for the last response.
   initial begin : stimulus
      logic [STEP_W-1:0] steps [6];
      int                count, len;
      steps = '{24'hFF_FFFF, 24'd0, STEP_RESET, 24'($urandom),
                24'($urandom_range(1, 255)), 24'($urandom)};

      // One vector for each phase before steady; phases that first write history sweep every index.
      for (int p = 1; p < 8; p++) begin
         if (p == int'(PHASE_1) || p == int'(PHASE_2) || p == int'(PHASE_5)) begin
            push_vector(1'b1, $urandom_range(0, 4));
         end else begin
            push_vector(1'b0, $urandom_range(1, 24));
         end
      end

      // Steady phase under several step sizes, extremes included.
      foreach (steps[k]) begin
         push_step_size(steps[k]);
         count = 0;
         while (count < SEGMENT_ITEMS) begin
            len = $urandom_range(1, 16);
            push_vector(1'b0, len);
            count += len;
         end
      end

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      while (req_accepted != items_total || awaited_rsp.size() != 0) @(negedge clock);
      repeat (END_CYCLES) @(negedge clock);
      if (fail_count == 0 && awaited_rsp.size() == 0) begin
         $display("adams_bashforth3_integrator verification clean");
      end else begin
         $display("adams_bashforth3_integrator verification failed");
      end
      $finish;
   end

endmodule
